### design/usc_pkg.sv
// usc_pkg: shared constants and byte classification for the URL span scanner.
// No dependencies; used by the interfaces, the scanner, its checker and the testbench.
package usc_pkg;

  localparam int unsigned MAX_LINE_DEF = 65535;
  localparam int unsigned OFS_W = 16;
  localparam int unsigned CH_W = 8;

  localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;

  localparam logic [1:0] SEP_NONE  = 2'd0;
  localparam logic [1:0] SEP_COLON = 2'd1;
  localparam logic [1:0] SEP_SLASH = 2'd2;
  localparam logic [1:0] SEP_FULL  = 2'd3;

  typedef logic [OFS_W-1:0] ofs_t;

  function automatic logic is_alpha(input logic [CH_W-1:0] c);
    logic r;
    r = 1'b0;
    case (c) inside
      [8'h61:8'h7A], [8'h41:8'h5A]: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_url_char(input logic [CH_W-1:0] c);
    logic r;
    r = 1'b0;
    case (c) inside
      [8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]: r = 1'b1;
      8'h7E, 8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h3D, 8'h26, 8'h24,
      8'h2D, 8'h5F, 8'h2E, 8'h2B, 8'h27, 8'h28, 8'h29, 8'h2C: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### design/usc_stream_if.sv
// usc_in_if / usc_out_if: valid/ready channels for text bytes and URL results.
// Depend on usc_pkg for field widths.
interface usc_in_if;
  logic                     valid;
  logic                     ready;
  logic [usc_pkg::CH_W-1:0] ch;
  logic                     last_in_line;

  modport source (output valid, ch, last_in_line, input ready);
  modport sink   (input valid, ch, last_in_line, output ready);
endinterface

interface usc_out_if;
  logic          valid;
  logic          ready;
  logic          url_found;
  usc_pkg::ofs_t url_start;
  usc_pkg::ofs_t url_stop;
  logic          line_done;

  modport source (output valid, url_found, url_start, url_stop, line_done, input ready);
  modport sink   (input valid, url_found, url_start, url_stop, line_done, output ready);
endinterface

### design/url_span_scanner.sv
// url_span_scanner: streaming detector of letters "://" URL spans within text lines.
// Depends on usc_pkg and the channel interfaces in usc_stream_if.sv.
//
//   channel | dir | payload                                     | word
//   in_i    | in  | ch[7:0], last_in_line                       | one text byte
//   out_o   | out | url_found, url_start[15:0], url_stop[15:0], | one result per byte
//           |     | line_done                                   |
//
// One byte per cycle: the byte is classified and the scan state updated in the
// accepting cycle, and the result sits in the output register in the next cycle.
// in_i.ready is high while the output register is empty or being taken, so a
// stalled sink stops input only once its result is held.
// rst_ni clears the scan state and empties the output register.
module url_span_scanner #(
  parameter int unsigned MaxLine = usc_pkg::MAX_LINE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  usc_in_if.sink    in_i,
  usc_out_if.source out_o
);
  import usc_pkg::*;

  localparam ofs_t PosCap = (MaxLine < 32'd65535) ? ofs_t'(MaxLine) : ofs_t'(16'hFFFF);

  ofs_t       pos_q, pos_d;
  ofs_t       let_start_q, let_start_d;
  logic       let_act_q, let_act_d;
  logic [1:0] sep_q, sep_d;
  ofs_t       cand_start_q, cand_start_d;
  logic       cand_vld_q, cand_vld_d;
  logic       inside_q, inside_d;
  ofs_t       open_start_q, open_start_d;

  logic       out_vld_q;
  logic       found_q, found_d;
  ofs_t       start_q, start_d;
  ofs_t       stop_q, stop_d;
  logic       done_q;

  logic       accept;
  logic       urlc;
  ofs_t       pos_inc;

  assign in_i.ready = !out_vld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign urlc       = is_url_char(in_i.ch);
  assign pos_inc    = (pos_q >= PosCap) ? PosCap : pos_q + ofs_t'(1);

  always_comb begin
    inside_d     = inside_q;
    open_start_d = open_start_q;
    sep_d        = sep_q;
    cand_vld_d   = cand_vld_q;
    cand_start_d = cand_start_q;
    let_act_d    = let_act_q;
    let_start_d  = let_start_q;
    found_d      = 1'b0;
    start_d      = '0;
    stop_d       = '0;

    if (inside_q) begin
      if (!urlc) begin
        found_d  = 1'b1;
        start_d  = open_start_q;
        stop_d   = pos_q;
        inside_d = 1'b0;
      end
    end else if (sep_q == SEP_FULL && cand_vld_q && urlc) begin
      inside_d     = 1'b1;
      open_start_d = cand_start_q;
    end

    if (inside_d) begin
      sep_d      = SEP_NONE;
      cand_vld_d = 1'b0;
      let_act_d  = 1'b0;
      if (in_i.last_in_line) begin
        found_d  = 1'b1;
        start_d  = open_start_d;
        stop_d   = pos_inc;
        inside_d = 1'b0;
      end
    end else begin
      if (in_i.ch == CH_COLON) begin
        sep_d        = SEP_COLON;
        cand_vld_d   = let_act_q;
        cand_start_d = let_start_q;
      end else if (in_i.ch == CH_SLASH && sep_q == SEP_COLON) begin
        sep_d = SEP_SLASH;
      end else if (in_i.ch == CH_SLASH && sep_q == SEP_SLASH) begin
        sep_d = SEP_FULL;
      end else begin
        sep_d = SEP_NONE;
      end
      if (is_alpha(in_i.ch)) begin
        if (!let_act_q) begin
          let_start_d = pos_q;
        end
        let_act_d = 1'b1;
      end else begin
        let_act_d = 1'b0;
      end
    end

    pos_d = pos_inc;
    if (in_i.last_in_line) begin
      pos_d        = '0;
      let_start_d  = '0;
      let_act_d    = 1'b0;
      sep_d        = SEP_NONE;
      cand_start_d = '0;
      cand_vld_d   = 1'b0;
      inside_d     = 1'b0;
      open_start_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      let_start_q  <= '0;
      let_act_q    <= 1'b0;
      sep_q        <= SEP_NONE;
      cand_start_q <= '0;
      cand_vld_q   <= 1'b0;
      inside_q     <= 1'b0;
      open_start_q <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      if (accept) begin
        pos_q        <= pos_d;
        let_start_q  <= let_start_d;
        let_act_q    <= let_act_d;
        sep_q        <= sep_d;
        cand_start_q <= cand_start_d;
        cand_vld_q   <= cand_vld_d;
        inside_q     <= inside_d;
        open_start_q <= open_start_d;
        out_vld_q    <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      found_q <= found_d;
      start_q <= start_d;
      stop_q  <= stop_d;
      done_q  <= in_i.last_in_line;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.url_found = found_q;
  assign out_o.url_start = start_q;
  assign out_o.url_stop  = stop_q;
  assign out_o.line_done = done_q;

endmodule

### design/usc_checker.sv
// usc_checker: port-level checks on url_span_scanner, attached by bind.
// Depends on usc_pkg and, through the bind, on the scanner's channel interfaces.
module usc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input logic          url_found_i,
  input usc_pkg::ofs_t url_start_i,
  input usc_pkg::ofs_t url_stop_i,
  input logic          line_done_i
);
  import usc_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(url_found_i)
      && $stable(url_start_i) && $stable(url_stop_i) && $stable(line_done_i))
    else $error("result word changed while stalled");

  a_accept_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted byte produced no result word");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !url_found_i |-> url_start_i == '0 && url_stop_i == '0)
    else $error("offsets nonzero without a URL");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && url_found_i |-> url_start_i <= url_stop_i)
    else $error("URL span ends before it starts");

endmodule

bind url_span_scanner usc_checker u_usc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .url_found_i (out_o.url_found),
  .url_start_i (out_o.url_start),
  .url_stop_i  (out_o.url_stop),
  .line_done_i (out_o.line_done)
);

### tb/url_span_scanner_tb.sv
// url_span_scanner_tb: directed and randomized check of the URL span scanner against its own span predictor.
// Depends on usc_pkg, usc_in_if/usc_out_if and url_span_scanner from the design folder.
`timescale 1ns / 1ps

module url_span_scanner_tb;
  import usc_pkg::*;

  typedef struct {
    logic [CH_W-1:0] ch;
    logic            last;
  } text_byte_t;

  typedef struct packed {
    logic url_found;
    ofs_t url_start;
    ofs_t url_stop;
    logic line_done;
  } span_word_t;

  class url_scoreboard;
    localparam int unsigned POS_CAP = (MAX_LINE_DEF < 65535) ? MAX_LINE_DEF : 65535;
    localparam string URL_EXTRA = "~;/?:@=&$-_.+'(),";

    int unsigned errors;
    span_word_t  pending_spans[$];

    ofs_t       pos;
    ofs_t       run_start;
    logic       in_letters;
    logic [1:0] sep;
    ofs_t       cand_start;
    logic       cand_ok;
    logic       in_url;
    ofs_t       url_open;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      pos        = '0;
      run_start  = '0;
      in_letters = 1'b0;
      sep        = SEP_NONE;
      cand_start = '0;
      cand_ok    = 1'b0;
      in_url     = 1'b0;
      url_open   = '0;
    endfunction

    function logic is_letter_byte(logic [CH_W-1:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function logic is_url_byte(logic [CH_W-1:0] c);
      if (is_letter_byte(c) || (c >= "0" && c <= "9")) begin
        return 1'b1;
      end
      for (int k = 0; k < URL_EXTRA.len(); k++) begin
        if (URL_EXTRA[k] == c) begin
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function ofs_t bump(ofs_t v);
      return (v >= POS_CAP) ? ofs_t'(POS_CAP) : ofs_t'(v + 1);
    endfunction

    function span_word_t scan_byte(logic [CH_W-1:0] ch, logic last);
      span_word_t r;
      logic       urlc;
      r = '0;
      r.line_done = last;
      urlc = is_url_byte(ch);
      if (in_url) begin
        if (!urlc) begin
          r.url_found = 1'b1;
          r.url_start = url_open;
          r.url_stop  = pos;
          in_url      = 1'b0;
        end
      end else if (sep == SEP_FULL && cand_ok && urlc) begin
        in_url   = 1'b1;
        url_open = cand_start;
      end
      if (in_url) begin
        sep        = SEP_NONE;
        cand_ok    = 1'b0;
        in_letters = 1'b0;
        if (last) begin
          r.url_found = 1'b1;
          r.url_start = url_open;
          r.url_stop  = bump(pos);
          in_url      = 1'b0;
        end
      end else begin
        if (ch == CH_COLON) begin
          sep        = SEP_COLON;
          cand_ok    = in_letters;
          cand_start = run_start;
        end else if (ch == CH_SLASH && (sep == SEP_COLON || sep == SEP_SLASH)) begin
          sep = (sep == SEP_COLON) ? SEP_SLASH : SEP_FULL;
        end else begin
          sep = SEP_NONE;
        end
        if (is_letter_byte(ch)) begin
          if (!in_letters) run_start = pos;
          in_letters = 1'b1;
        end else begin
          in_letters = 1'b0;
        end
      end
      if (last) clear();
      else pos = bump(pos);
      return r;
    endfunction

    function void note_byte(logic [CH_W-1:0] ch, logic last);
      pending_spans.insert(pending_spans.size(), scan_byte(ch, last));
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(span_word_t got);
      span_word_t want;
      if (pending_spans.size() == 0) begin
        report($sformatf("word with nothing expected: %p", got));
        return;
      end
      want = pending_spans.pop_front();
      if (got.url_found !== want.url_found)
        report($sformatf("url_found %b, want %b", got.url_found, want.url_found));
      if (got.url_start !== want.url_start)
        report($sformatf("url_start %0d, want %0d", got.url_start, want.url_start));
      if (got.url_stop !== want.url_stop)
        report($sformatf("url_stop %0d, want %0d", got.url_stop, want.url_stop));
      if (got.line_done !== want.line_done)
        report($sformatf("line_done %b, want %b", got.line_done, want.line_done));
    endtask

    task check_drained();
      if (pending_spans.size() != 0)
        report($sformatf("%0d words never arrived", pending_spans.size()));
    endtask
  endclass

  localparam int    RANDOM_BYTES = 1500;
  localparam string URL_SET =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789~;/?:@=&$-_.+'(),";

  logic clk;
  logic rst_n;

  usc_in_if  in_if ();
  usc_out_if out_if ();

  url_span_scanner u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  url_scoreboard sb = new();
  text_byte_t    text_q[$];
  int            rand_base;
  int            words_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("url_span_scanner verification failed");
    $finish;
  end

  task push_byte(logic [CH_W-1:0] c);
    text_byte_t b;
    b.ch   = c;
    b.last = 1'b0;
    text_q.insert(text_q.size(), b);
  endtask

  task push_text(string s);
    for (int k = 0; k < s.len(); k++) push_byte(s[k]);
  endtask

  task end_line();
    text_q[text_q.size()-1].last = 1'b1;
  endtask

  function logic [CH_W-1:0] rand_letter();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                : 8'("A" + $urandom_range(0, 25));
  endfunction

  function logic [CH_W-1:0] rand_url_byte();
    return URL_SET[$urandom_range(0, URL_SET.len() - 1)];
  endfunction

  function logic [CH_W-1:0] rand_stop_byte();
    case ($urandom_range(0, 3))
      0: return " ";
      1: return 8'($urandom_range(128, 255));
      2: return 8'($urandom_range(0, 31));
      default: return "<";
    endcase
  endfunction

  task gen_line();
    int nseg;
    nseg = $urandom_range(1, 4);
    repeat (nseg) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          if ($urandom_range(0, 4) == 0) push_byte(rand_url_byte());
          repeat ($urandom_range(1, 4)) push_byte(rand_letter());
          if ($urandom_range(0, 5) == 0) push_byte(CH_COLON);
          case ($urandom_range(0, 7))
            0: push_text(":/");
            1: push_text(":x/");
            default: push_text("://");
          endcase
          repeat ($urandom_range(0, 8)) push_byte(rand_url_byte());
          if ($urandom_range(0, 1)) push_byte(rand_stop_byte());
        end
        6, 7: begin
          repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
        end
        default: begin
          repeat ($urandom_range(1, 5)) begin
            push_byte($urandom_range(0, 3) ? rand_letter() : 8'("0" + $urandom_range(0, 9)));
          end
          push_byte(" ");
        end
      endcase
    end
    end_line();
  endtask

  task build_text();
    push_byte(8'h00);
    push_text("z://");
    push_byte(8'hFF);
    end_line();
    push_text("a:b://c://d");
    end_line();
    push_text("7://x");
    end_line();
    push_text("p::/q://");
    push_byte(8'h80);
    end_line();
    push_byte(8'h7F);
    end_line();

    rand_base = text_q.size();
    while (text_q.size() < rand_base + RANDOM_BYTES) gen_line();
  endtask

  initial begin : sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && words_seen >= rand_base + 300) begin
        out_if.ready <= 1'b0;
        hold_left = 299;
        hold_done = 1;
      end else if (words_seen >= rand_base + 600 && words_seen < rand_base + 900) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= 18);
      end
    end
  end

  always @(posedge clk) begin : take_word
    span_word_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.url_found = out_if.url_found;
      got.url_start = out_if.url_start;
      got.url_stop  = out_if.url_stop;
      got.line_done = out_if.line_done;
      sb.check_result(got);
      words_seen++;
    end
  end

  initial begin : source
    bit quiet;
    rand_base  = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.ch = '0;
    in_if.last_in_line = 1'b0;
    build_text();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < text_q.size(); i++) begin
      if (i == rand_base + 1000) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (sb.pending_spans.size() != 0) @(posedge clk);
      end
      quiet = (i >= rand_base + 600 && i < rand_base + 900);
      forever begin
        @(negedge clk);
        if (!quiet && $urandom_range(0, 99) < 18) in_if.valid <= 1'b0;
        else break;
      end
      in_if.valid        <= 1'b1;
      in_if.ch           <= text_q[i].ch;
      in_if.last_in_line <= text_q[i].last;
      do @(posedge clk); while (!in_if.ready);
      sb.note_byte(text_q[i].ch, text_q[i].last);
    end
    @(negedge clk);
    in_if.valid <= 1'b0;

    while (sb.pending_spans.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("url_span_scanner verification clean");
    end else begin
      $display("url_span_scanner verification failed");
    end
    $finish;
  end
endmodule
